>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif

`endif

>>> sv/nnsc_pkg.sv
package nnsc_pkg;

   localparam int MAX_DIM         = 4096;
   localparam int SCALE_FRAC_BITS = 16;

   localparam int COORD_W = 12;
   localparam int DIM_W   = 13;
   localparam int SCALE_W = 24;
   localparam int PROD_W  = COORD_W + SCALE_W;
   localparam int CSR_IDX_W = 3;

   // Largest source coordinate: limited by the frame size and by the field width.
   localparam int COORD_MAX   = (1 << COORD_W) - 1;
   localparam int COORD_LIMIT = ((MAX_DIM - 1) < COORD_MAX) ? (MAX_DIM - 1) : COORD_MAX;

   // Item kinds.
   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // Source codes.
   localparam logic [1:0] SRC_BLACK = 2'd0;
   localparam logic [1:0] SRC_IN0   = 2'd1;
   localparam logic [1:0] SRC_IN1   = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_CANVAS_COLS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WIN0_WIDTH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WIN0_HEIGHT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WIN0_INV_SCALE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WIN1_WIDTH     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WIN1_HEIGHT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_WIN1_INV_SCALE = 3'd6;

   typedef struct packed {
      logic [DIM_W-1:0]   canvas_cols;
      logic [DIM_W-1:0]   win0_width;
      logic [DIM_W-1:0]   win0_height;
      logic [SCALE_W-1:0] win0_inv_scale;
      logic [DIM_W-1:0]   win1_width;
      logic [DIM_W-1:0]   win1_height;
      logic [SCALE_W-1:0] win1_inv_scale;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         source;
      logic [COORD_W-1:0] off_x;
      logic [COORD_W-1:0] off_y;
      logic [SCALE_W-1:0] scale;
   } sel_type;

endpackage

>>> sv/nnsc_window_select.sv
module nnsc_window_select (
   input  nnsc_pkg::cfg_type                cfg,
   input  logic [nnsc_pkg::COORD_W-1:0]     x,
   input  logic [nnsc_pkg::COORD_W-1:0]     y,
   input  logic [1:0]                       seen,
   output nnsc_pkg::sel_type                sel
);

   logic [nnsc_pkg::COORD_W-1:0] x1;
   logic [nnsc_pkg::COORD_W-1:0] off1;
   logic                         in_canvas;
   logic                         hit0;
   logic                         hit1;

   assign x1        = cfg.canvas_cols[nnsc_pkg::DIM_W-1:1];
   assign off1      = x - x1;
   assign in_canvas = {1'b0, x} < cfg.canvas_cols;

   assign hit1 = seen[1] && (x >= x1) && ({1'b0, off1} < cfg.win1_width)
                 && ({1'b0, y} < cfg.win1_height);
   assign hit0 = seen[0] && ({1'b0, x} < cfg.win0_width)
                 && ({1'b0, y} < cfg.win0_height);

   // Window 1 is drawn on top of window 0. Black pixels carry a zero scale so
   // that their coordinates come out as zero.
   always_comb begin
      sel = '0;
      if (in_canvas && hit1) begin
         sel.source = nnsc_pkg::SRC_IN1;
         sel.off_x  = off1;
         sel.off_y  = y;
         sel.scale  = cfg.win1_inv_scale;
      end else if (in_canvas && hit0) begin
         sel.source = nnsc_pkg::SRC_IN0;
         sel.off_x  = x;
         sel.off_y  = y;
         sel.scale  = cfg.win0_inv_scale;
      end
   end

endmodule

>>> sv/nearest_neighbor_scale_compositor.sv
// A pixel request passes the input stage, multiply stage and output register to rsp_tvalid.
// Throughput: one request per cycle unless rsp_tready stalls; both multipliers are pipelined.
// Frame arrival requests update the frame flags at acceptance and give no response.
// Reset (synchronous, active high) empties the pipeline, clears both frame flags and
// restores the register defaults.
`include "assert_macros.svh"

module nearest_neighbor_scale_compositor (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [0] input_index, [1] frame_nonempty, [13:2] canvas_x, [25:14] canvas_y, [31:26] zero
   input  logic [31:0]                       req_tdata,
   // [0] kind
   input  logic                              req_tuser,
   // Response channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [11:0] src_col, [23:12] src_row
   output logic [23:0]                       rsp_tdata,
   // [1:0] source
   output logic [1:0]                        rsp_tuser,
   // Register write channel.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [nnsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nnsc_pkg::SCALE_W-1:0]      csr_data
);

   localparam int CW = nnsc_pkg::COORD_W;
   localparam int PW = nnsc_pkg::PROD_W;

   nnsc_pkg::cfg_type cfg_ff;
   logic [1:0]        frame_seen_ff;
   logic [1:0]        frame_seen_in;

   logic              s1_valid_ff;
   logic [CW-1:0]     s1_x_ff;
   logic [CW-1:0]     s1_y_ff;
   logic [1:0]        s1_seen_ff;

   logic              s2_valid_ff;
   logic [1:0]        s2_source_ff;
   logic [PW-1:0]     s2_col_prod_ff;
   logic [PW-1:0]     s2_row_prod_ff;

   logic              rsp_valid_ff;
   logic [1:0]        rsp_source_ff;
   logic [CW-1:0]     rsp_col_ff;
   logic [CW-1:0]     rsp_row_ff;

   logic              out_en;
   logic              s2_en;
   logic              s1_en;
   logic              req_fire;

   nnsc_pkg::sel_type sel;
   logic [PW-1:0]     col_shift;
   logic [PW-1:0]     row_shift;
   logic [CW-1:0]     col_sat;
   logic [CW-1:0]     row_sat;

   // Each stage moves when the one after it is empty or moving.
   assign out_en     = !rsp_valid_ff || rsp_tready;
   assign s2_en      = !s2_valid_ff || out_en;
   assign s1_en      = !s1_valid_ff || s2_en;
   assign req_tready = s1_en;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.canvas_cols    <= 13'd1280;
         cfg_ff.win0_width     <= 13'd480;
         cfg_ff.win0_height    <= 13'd360;
         cfg_ff.win0_inv_scale <= 24'd131072;
         cfg_ff.win1_width     <= 13'd480;
         cfg_ff.win1_height    <= 13'd360;
         cfg_ff.win1_inv_scale <= 24'd131072;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            nnsc_pkg::REG_CANVAS_COLS:    cfg_ff.canvas_cols    <= csr_data[12:0];
            nnsc_pkg::REG_WIN0_WIDTH:     cfg_ff.win0_width     <= csr_data[12:0];
            nnsc_pkg::REG_WIN0_HEIGHT:    cfg_ff.win0_height    <= csr_data[12:0];
            nnsc_pkg::REG_WIN0_INV_SCALE: cfg_ff.win0_inv_scale <= csr_data;
            nnsc_pkg::REG_WIN1_WIDTH:     cfg_ff.win1_width     <= csr_data[12:0];
            nnsc_pkg::REG_WIN1_HEIGHT:    cfg_ff.win1_height    <= csr_data[12:0];
            nnsc_pkg::REG_WIN1_INV_SCALE: cfg_ff.win1_inv_scale <= csr_data;
            default: ;
         endcase
      end
   end

   // Frame flags only ever get set; an empty frame leaves them alone.
   always_comb begin
      frame_seen_in = frame_seen_ff;
      if (req_fire && req_tuser == nnsc_pkg::KIND_FRAME && req_tdata[1]) begin
         frame_seen_in[req_tdata[0]] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_seen_ff <= '0;
      end else begin
         frame_seen_ff <= frame_seen_in;
      end
   end

   // Input stage. A query keeps the frame flags as they stood when it was
   // accepted, so later frame arrivals do not reach back into it.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_tvalid && req_tuser == nnsc_pkg::KIND_QUERY;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_x_ff    <= req_tdata[13:2];
         s1_y_ff    <= req_tdata[25:14];
         s1_seen_ff <= frame_seen_ff;
      end
   end

   nnsc_window_select u_select (
      .cfg  (cfg_ff),
      .x    (s1_x_ff),
      .y    (s1_y_ff),
      .seen (s1_seen_ff),
      .sel  (sel)
   );

   // Multiply stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_source_ff   <= sel.source;
         s2_col_prod_ff <= PW'(sel.off_x) * PW'(sel.scale);
         s2_row_prod_ff <= PW'(sel.off_y) * PW'(sel.scale);
      end
   end

   // Drop the fraction and clamp to the largest source coordinate.
   assign col_shift = s2_col_prod_ff >> nnsc_pkg::SCALE_FRAC_BITS;
   assign row_shift = s2_row_prod_ff >> nnsc_pkg::SCALE_FRAC_BITS;
   assign col_sat   = (col_shift > PW'(nnsc_pkg::COORD_LIMIT)) ?
                      CW'(nnsc_pkg::COORD_LIMIT) : col_shift[CW-1:0];
   assign row_sat   = (row_shift > PW'(nnsc_pkg::COORD_LIMIT)) ?
                      CW'(nnsc_pkg::COORD_LIMIT) : row_shift[CW-1:0];

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_source_ff <= s2_source_ff;
         rsp_col_ff    <= col_sat;
         rsp_row_ff    <= row_sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_source_ff;
   assign rsp_tdata  = {rsp_row_ff, rsp_col_ff};

   `ASSERT_PROP(a_black_zero, clock, reset, (rsp_tvalid && rsp_tuser == nnsc_pkg::SRC_BLACK) |-> (rsp_tdata == '0))
   `ASSERT_PROP(a_frame_no_rsp, clock, reset, (req_fire && req_tuser == nnsc_pkg::KIND_FRAME) |=> !s1_valid_ff)
   `ASSERT_NEVER(a_flag_cleared, clock, reset, $fell(frame_seen_ff[0]) || $fell(frame_seen_ff[1]))

endmodule
